// File: rtl/lru_page_replacement_unit_macros.svh
// ----------------------------------------------------------------------------
// LRU page replacement unit: assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// Same-cycle implication.
`define LRU_PR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRU_PR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lru_pr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_pr_pkg
// Shared constants and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package lru_pr_pkg;

  localparam int CFG_BITS = 5;
  localparam logic [CFG_BITS-1:0] FRAMES_IN_USE_RESET = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic lookup;   // compare tags, pick the slot, apply restart
    logic commit;   // update frames and recency, load the result
  } lru_pr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic result_full;  // result register holds an untaken result
  } lru_pr_status_t;

endpackage
`default_nettype wire

// File: rtl/lru_pr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_pr_if
// Valid/ready channels of the LRU page replacement unit.
// ----------------------------------------------------------------------------
interface lru_pr_req_if #(
  parameter int PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;
  logic                 restart;

  modport source (output valid, output page, output restart, input ready);
  modport sink   (input valid, input page, input restart, output ready);
endinterface

interface lru_pr_rsp_if #(
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic                  victim_valid;
  logic [PAGE_BITS-1:0]  victim_page;
  logic [COUNT_BITS-1:0] miss_count;
  logic [COUNT_BITS-1:0] reference_count;

  modport source (output valid, output hit, output victim_valid, output victim_page,
                  output miss_count, output reference_count, input ready);
  modport sink   (input valid, input hit, input victim_valid, input victim_page,
                  input miss_count, input reference_count, output ready);
endinterface

interface lru_pr_cfg_if import lru_pr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/lru_pr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lru_page_replacement_unit_macros.svh"
// ----------------------------------------------------------------------------
// lru_pr_ctrl
// Sequencer: capture, lookup and commit of one request at a time.
// ----------------------------------------------------------------------------
module lru_pr_ctrl import lru_pr_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           out_ready,
  input  wire lru_pr_status_t status,
  output logic                in_ready,
  output lru_pr_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !status.result_full || out_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the result register can take the outcome
        if (out_free) begin
          cmd.commit = 1'b1;
          in_ready   = 1'b1;
          state_next = in_valid ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    cmd.capture = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `LRU_PR_ASSERT_IMP(a_commit_room, cmd.commit, out_free, "commit with result register full")
  `LRU_PR_ASSERT_NEXT(a_capture_lookup, cmd.capture, state == ST_LOOKUP,
                      "captured request not looked up")
  `LRU_PR_ASSERT_NEXT(a_lookup_commit, cmd.lookup, state == ST_COMMIT,
                      "lookup not followed by commit")

endmodule
`default_nettype wire

// File: rtl/lru_pr_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lru_page_replacement_unit_macros.svh"
// ----------------------------------------------------------------------------
// lru_pr_dpath
// Frame table, recency ranks, counters and result register.
// ----------------------------------------------------------------------------
module lru_pr_dpath import lru_pr_pkg::*; #(
  parameter int FRAMES     = 16,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lru_pr_cmd_t           cmd,
  output lru_pr_status_t             status,
  input  wire logic [PAGE_BITS-1:0]  in_page,
  input  wire logic                  in_restart,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_BITS-1:0]   cfg_data,
  input  wire logic                  out_ready,
  output logic                       res_hit,
  output logic                       res_victim_valid,
  output logic [PAGE_BITS-1:0]       res_victim_page,
  output logic [COUNT_BITS-1:0]      res_miss_count,
  output logic [COUNT_BITS-1:0]      res_reference_count
);

  localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int OCC_BITS = $clog2(FRAMES + 1);
  localparam int LIM_BITS = (OCC_BITS > CFG_BITS) ? OCC_BITS : CFG_BITS;

  logic [CFG_BITS-1:0]   frames_in_use;
  logic [PAGE_BITS-1:0]  req_page;
  logic                  req_restart;

  logic [PAGE_BITS-1:0]  frame_page [FRAMES];
  logic [FRAMES-1:0]     frame_valid;
  logic [IDX_BITS-1:0]   frame_rank [FRAMES];
  logic [OCC_BITS-1:0]   occupied;
  logic [COUNT_BITS-1:0] miss_total;
  logic [COUNT_BITS-1:0] reference_total;

  // lookup results
  logic                  lk_hit;
  logic                  lk_evict;
  logic [IDX_BITS-1:0]   lk_slot;
  logic [IDX_BITS-1:0]   lk_rank;
  logic [PAGE_BITS-1:0]  lk_victim_page;

  logic                  result_full;

  // lookup logic
  logic [FRAMES-1:0]     valid_eff;
  logic [OCC_BITS-1:0]   occ_eff;
  logic [OCC_BITS-1:0]   lru_rank_full;
  logic [FRAMES-1:0]     match;
  logic [FRAMES-1:0]     lru_oh;
  logic [FRAMES-1:0]     free_oh;
  logic [IDX_BITS-1:0]   hit_idx;
  logic [IDX_BITS-1:0]   lru_idx;
  logic [IDX_BITS-1:0]   free_idx;
  logic [IDX_BITS-1:0]   slot_sel;
  logic [LIM_BITS-1:0]   cfg_wide;
  logic [LIM_BITS-1:0]   limit;
  logic                  any_hit;
  logic                  at_limit;

  logic                  lk_insert;
  logic [COUNT_BITS-1:0] miss_next;
  logic [COUNT_BITS-1:0] reference_next;

  // clamp the frame limit into 1..FRAMES
  always_comb begin
    cfg_wide = LIM_BITS'(frames_in_use);
    if (cfg_wide == '0) begin
      limit = LIM_BITS'(1);
    end else if (cfg_wide > LIM_BITS'(FRAMES)) begin
      limit = LIM_BITS'(FRAMES);
    end else begin
      limit = cfg_wide;
    end
  end

  // a restarting request sees an empty table
  assign valid_eff     = req_restart ? '0 : frame_valid;
  assign occ_eff       = req_restart ? '0 : occupied;
  assign lru_rank_full = occ_eff - OCC_BITS'(1);
  assign at_limit      = LIM_BITS'(occ_eff) >= limit;
  assign free_oh       = ~valid_eff & FRAMES'(valid_eff + FRAMES'(1));

  // pages and ranks of valid frames are unique, so each vector below has at most one bit set
  always_comb begin
    hit_idx  = '0;
    lru_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      match[i]  = valid_eff[i] && (frame_page[i] == req_page);
      lru_oh[i] = valid_eff[i] && (frame_rank[i] == lru_rank_full[IDX_BITS-1:0]);
      if (match[i]) begin
        hit_idx = hit_idx | IDX_BITS'(i);
      end
      if (lru_oh[i]) begin
        lru_idx = lru_idx | IDX_BITS'(i);
      end
      if (free_oh[i]) begin
        free_idx = free_idx | IDX_BITS'(i);
      end
    end
    any_hit  = |match;
    slot_sel = any_hit ? hit_idx : (at_limit ? lru_idx : free_idx);
  end

  assign lk_insert      = !lk_hit && !lk_evict;
  assign miss_next      = lk_hit ? miss_total :
                          ((miss_total == '1) ? miss_total : miss_total + 1'b1);
  assign reference_next = (reference_total == '1) ? reference_total
                                                  : reference_total + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_IN_USE_RESET;
    end else if (cfg_we) begin
      frames_in_use <= cfg_data;
    end
  end

  // request, lookup and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_page    <= in_page;
      req_restart <= in_restart;
    end
    if (cmd.lookup) begin
      lk_hit         <= any_hit;
      lk_evict       <= !any_hit && at_limit;
      lk_slot        <= slot_sel;
      lk_rank        <= frame_rank[slot_sel];
      lk_victim_page <= frame_page[slot_sel];
    end
    if (cmd.commit) begin
      res_hit             <= lk_hit;
      res_victim_valid    <= lk_evict;
      res_victim_page     <= lk_evict ? lk_victim_page : '0;
      res_miss_count      <= miss_next;
      res_reference_count <= reference_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !lk_hit) begin
      frame_page[lk_slot] <= req_page;
    end
  end

  // table state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid     <= '0;
      occupied        <= '0;
      miss_total      <= '0;
      reference_total <= '0;
      result_full     <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        frame_rank[i] <= '0;
      end
    end else begin
      if (cmd.lookup && req_restart) begin
        frame_valid     <= '0;
        occupied        <= '0;
        miss_total      <= '0;
        reference_total <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          frame_rank[i] <= '0;
        end
      end
      if (cmd.commit) begin
        miss_total      <= miss_next;
        reference_total <= reference_next;
        // age the frames more recent than the promoted one
        for (int i = 0; i < FRAMES; i++) begin
          if (frame_valid[i] && (IDX_BITS'(i) != lk_slot) &&
              (lk_insert || (frame_rank[i] < lk_rank))) begin
            frame_rank[i] <= frame_rank[i] + 1'b1;
          end
        end
        frame_rank[lk_slot] <= '0;
        if (lk_insert) begin
          frame_valid[lk_slot] <= 1'b1;
          occupied             <= occupied + 1'b1;
        end
        result_full <= 1'b1;
      end else if (out_ready) begin
        result_full <= 1'b0;
      end
    end
  end

  assign status.result_full = result_full;

  `LRU_PR_ASSERT_IMP(a_occ_matches_valid, 1'b1,
                     occupied == OCC_BITS'($countones(frame_valid)),
                     "occupancy differs from valid frame count")
  `LRU_PR_ASSERT_NEXT(a_insert_grows, cmd.commit && lk_insert,
                      occupied == OCC_BITS'($past(occupied) + 1'b1),
                      "insert did not grow occupancy")

endmodule
`default_nettype wire

// File: rtl/lru_page_replacement_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// Fully associative LRU page frame tracker with miss and reference counters.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one page reference per request (page, restart); restart empties the
//          frames and zeroes both counters before the reference is handled.
//   rsp  - one result per request: hit, victim_valid, victim_page and the
//          saturating miss_count and reference_count including this request.
//   cfg  - write of frames_in_use (always ready); 0 acts as 1, anything above
//          FRAMES acts as FRAMES. Write it only while no request is in flight.
// Timing: an accepted request is compared against all frame tags in the
//   following cycle and committed once the result register can take it, when
//   its result appears on rsp. The lookup state registers the tag match and
//   victim choice, the commit state updates pages and recency ranks, and the
//   next request can be accepted on that commit edge, while the last one commits.
// Reset: all frames empty, counters zero, frames_in_use 16; no clearing pass,
//   so the unit takes requests from the first cycle after reset.
// Stall: while rsp is not taken the result is held, the commit waits and at
//   most one further request is captured.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit import lru_pr_pkg::*; #(
  parameter int FRAMES     = 16,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  lru_pr_req_if.sink  req,
  lru_pr_rsp_if.source rsp,
  lru_pr_cfg_if.sink  cfg
);

  lru_pr_cmd_t    cmd;
  lru_pr_status_t status;
  logic           in_ready;

  // sequencer: advance one request through lookup and commit
  lru_pr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // frame table, ranks, counters and the result register
  lru_pr_dpath #(
    .FRAMES     (FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .in_page             (req.page),
    .in_restart          (req.restart),
    .cfg_we              (cfg.valid),
    .cfg_data            (cfg.data),
    .out_ready           (rsp.ready),
    .res_hit             (rsp.hit),
    .res_victim_valid    (rsp.victim_valid),
    .res_victim_page     (rsp.victim_page),
    .res_miss_count      (rsp.miss_count),
    .res_reference_count (rsp.reference_count)
  );

  assign req.ready = in_ready;
  assign rsp.valid = status.result_full;
  // the limit register takes a write in any cycle
  assign cfg.ready = 1'b1;

endmodule
`default_nettype wire
